/* rtl/aqic_pkg.sv */
// Shared constants, types and breakpoint tables for the air quality index block.
// No dependencies; imported by every module of the block.
package aqic_pkg;

  // Table geometry and field widths
  localparam int TABLE_SLOTS          = 16;
  localparam int BREAKPOINT_COUNT_DEF = 7;
  localparam int CONC_W               = 16;
  localparam int INDEX_W              = 9;
  localparam int NUM_W                = CONC_W + INDEX_W;
  localparam int DVD_W                = NUM_W + 1;
  localparam int DVS_W                = CONC_W + 1;
  localparam int QUO_W                = INDEX_W;
  localparam int CAT_W                = 3;

  // Pipeline: segment search, multiply, one stage per quotient bit, output register
  localparam int PIPE_DEPTH = 2 + QUO_W + 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_STANDARD = '0;

  localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd500;

  typedef enum logic {
    STD_EPA  = 1'b0,
    STD_QCVN = 1'b1
  } standard_e;

  typedef enum logic {
    POLL_PM25 = 1'b0,
    POLL_PM10 = 1'b1
  } pollutant_e;

  typedef enum logic [CAT_W-1:0] {
    CAT_GOOD           = 3'd0,
    CAT_MODERATE       = 3'd1,
    CAT_SENSITIVE      = 3'd2,
    CAT_UNHEALTHY      = 3'd3,
    CAT_VERY_UNHEALTHY = 3'd4,
    CAT_HAZARDOUS      = 3'd5
  } category_e;

  // Upper index bound of each category
  localparam logic [INDEX_W-1:0] CAT_GOOD_MAX      = 9'd50;
  localparam logic [INDEX_W-1:0] CAT_MODERATE_MAX  = 9'd100;
  localparam logic [INDEX_W-1:0] CAT_SENSITIVE_MAX = 9'd150;
  localparam logic [INDEX_W-1:0] CAT_UNHEALTHY_MAX = 9'd200;
  localparam logic [INDEX_W-1:0] CAT_VERY_MAX      = 9'd300;

  typedef logic [CONC_W-1:0]  conc_tab_t  [TABLE_SLOTS];
  typedef logic [INDEX_W-1:0] index_tab_t [TABLE_SLOTS];

  // Concentration breakpoints in tenths of ug/m3; slots past the seventh are unset
  localparam conc_tab_t US_PM25_CONC = '{
    16'd0, 16'd120, 16'd354, 16'd554, 16'd1504, 16'd2504, 16'd5004, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
  localparam conc_tab_t US_PM10_CONC = '{
    16'd0, 16'd540, 16'd1540, 16'd2540, 16'd3540, 16'd4240, 16'd6040, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
  localparam conc_tab_t QC_PM25_CONC = '{
    16'd0, 16'd250, 16'd500, 16'd800, 16'd1500, 16'd3500, 16'd5000, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
  localparam conc_tab_t QC_PM10_CONC = '{
    16'd0, 16'd500, 16'd1500, 16'd2500, 16'd3500, 16'd4200, 16'd6000, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};

  // Index breakpoints, nondecreasing over the populated slots
  localparam index_tab_t INDEX_BP = '{
    9'd0, 9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd500, 9'd0,
    9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};

  // Segment stage result: everything the multiply stage needs
  typedef struct packed {
    logic [CONC_W-1:0]  delta;
    logic [CONC_W-1:0]  span;
    logic [INDEX_W-1:0] di;
    logic [INDEX_W-1:0] base;
    logic               special;
  } seg_t;

  // Divider stage state
  typedef struct packed {
    logic [DVD_W-1:0]   rem;
    logic [DVS_W-1:0]   dvs;
    logic [QUO_W-1:0]   quo;
    logic [INDEX_W-1:0] base;
  } div_t;

  function automatic conc_tab_t bp_table(pollutant_e poll, standard_e std);
    conc_tab_t tab;
    tab = US_PM25_CONC;
    case ({poll, std})
      {POLL_PM25, STD_EPA}:  tab = US_PM25_CONC;
      {POLL_PM25, STD_QCVN}: tab = QC_PM25_CONC;
      {POLL_PM10, STD_EPA}:  tab = US_PM10_CONC;
      {POLL_PM10, STD_QCVN}: tab = QC_PM10_CONC;
      default:               tab = US_PM25_CONC;
    endcase
    return tab;
  endfunction

  function automatic category_e category_of(logic [INDEX_W-1:0] aqi);
    category_e cat;
    if (aqi <= CAT_GOOD_MAX) begin
      cat = CAT_GOOD;
    end else if (aqi <= CAT_MODERATE_MAX) begin
      cat = CAT_MODERATE;
    end else if (aqi <= CAT_SENSITIVE_MAX) begin
      cat = CAT_SENSITIVE;
    end else if (aqi <= CAT_UNHEALTHY_MAX) begin
      cat = CAT_UNHEALTHY;
    end else if (aqi <= CAT_VERY_MAX) begin
      cat = CAT_VERY_UNHEALTHY;
    end else begin
      cat = CAT_HAZARDOUS;
    end
    return cat;
  endfunction

endpackage

/* rtl/aqic_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with base offset added.
// Depends on aqic_pkg.
module aqic_div
  import aqic_pkg::*;
(
  input  logic               clk_i,
  input  logic [QUO_W-1:0]   en_i,
  input  div_t               first_i,
  output logic [INDEX_W-1:0] sub_index_o
);

  div_t st_q [QUO_W];
  div_t st_d [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    div_t             src;
    logic [DVD_W-1:0] trial;

    assign src = (k == 0) ? first_i : st_q[(k == 0) ? 0 : k-1];

    // Try the shifted divisor at this bit; subtract when it fits
    always_comb begin
      st_d[k] = src;
      trial   = DVD_W'(src.dvs) << (QUO_W - 1 - k);
      if (src.rem >= trial) begin
        st_d[k].rem              = src.rem - trial;
        st_d[k].quo[QUO_W-1-k]   = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Rounded quotient on top of the segment's lower index
  assign sub_index_o = st_q[QUO_W-1].base + st_q[QUO_W-1].quo;

endmodule

/* rtl/aqic_lane.sv */
// One pollutant lane: segment search, interpolation multiply, divider pipeline.
// Depends on aqic_pkg and aqic_div.
module aqic_lane
  import aqic_pkg::*;
#(
  parameter int         BREAKPOINT_COUNT = BREAKPOINT_COUNT_DEF,
  parameter pollutant_e POLLUTANT        = POLL_PM25
) (
  input  logic                  clk_i,
  input  logic [PIPE_DEPTH-2:0] en_i,
  input  logic [CONC_W-1:0]     conc_i,
  input  standard_e             standard_i,
  output logic [INDEX_W-1:0]    sub_index_o
);

  localparam int NPTS = (BREAKPOINT_COUNT < 2) ? 2 :
                        ((BREAKPOINT_COUNT > TABLE_SLOTS) ? TABLE_SLOTS : BREAKPOINT_COUNT);

  conc_tab_t          bp;
  logic               found;
  logic [CONC_W-1:0]  lo, hi;
  logic [INDEX_W-1:0] ilo, ihi;
  seg_t               seg_d, seg_q;
  logic [NUM_W-1:0]   num;
  div_t               div_d, div_q;

  // Find the first segment that holds the concentration
  always_comb begin
    bp    = bp_table(POLLUTANT, standard_i);
    found = 1'b0;
    lo    = '0;
    hi    = '0;
    ilo   = '0;
    ihi   = '0;
    for (int i = NPTS - 2; i >= 0; i--) begin
      if (conc_i >= bp[i] && conc_i <= bp[i+1]) begin
        found = 1'b1;
        lo    = bp[i];
        hi    = bp[i+1];
        ilo   = INDEX_BP[i];
        ihi   = INDEX_BP[i+1];
      end
    end
  end

  // Resolve fixed results; otherwise hand over the interpolation terms
  always_comb begin
    seg_d         = '0;
    seg_d.special = 1'b1;
    if (conc_i == '0) begin
      seg_d.base = '0;
    end else if (conc_i >= bp[NPTS-1]) begin
      seg_d.base = INDEX_MAX;
    end else if (!found) begin
      seg_d.base = '0;
    end else if (hi == lo) begin
      seg_d.base = ilo;
    end else begin
      seg_d.special = 1'b0;
      seg_d.base    = ilo;
      seg_d.delta   = conc_i - lo;
      seg_d.span    = hi - lo;
      seg_d.di      = ihi - ilo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      seg_q <= seg_d;
    end
  end

  // Form 2*num + span over 2*span; a fixed result divides zero by one
  always_comb begin
    num        = NUM_W'(seg_q.di) * NUM_W'(seg_q.delta);
    div_d.quo  = '0;
    div_d.base = seg_q.base;
    if (seg_q.special) begin
      div_d.rem = '0;
      div_d.dvs = DVS_W'(1);
    end else begin
      div_d.rem = {num, 1'b0} + DVD_W'(seg_q.span);
      div_d.dvs = {seg_q.span, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      div_q <= div_d;
    end
  end

  aqic_div u_div (
    .clk_i       (clk_i),
    .en_i        (en_i[PIPE_DEPTH-2:2]),
    .first_i     (div_q),
    .sub_index_o (sub_index_o)
  );

endmodule

/* rtl/aqic_merge.sv */
// Merge stage: larger sub-index, dominant pollutant and category, registered out.
// Depends on aqic_pkg.
module aqic_merge
  import aqic_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [INDEX_W-1:0] pm25_index_i,
  input  logic [INDEX_W-1:0] pm10_index_i,
  output logic [INDEX_W-1:0] aqi_value_o,
  output logic [CAT_W-1:0]   category_level_o,
  output logic               dominant_pollutant_o
);

  logic [INDEX_W-1:0] aqi_d, aqi_q, pick;
  pollutant_e         dom_d, dom_q;
  category_e          cat_d, cat_q;

  // PM2.5 wins ties
  always_comb begin
    if (pm25_index_i >= pm10_index_i) begin
      pick  = pm25_index_i;
      dom_d = POLL_PM25;
    end else begin
      pick  = pm10_index_i;
      dom_d = POLL_PM10;
    end
    aqi_d = (pick > INDEX_MAX) ? INDEX_MAX : pick;
    cat_d = category_of(aqi_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aqi_q <= aqi_d;
      dom_q <= dom_d;
      cat_q <= cat_d;
    end
  end

  assign aqi_value_o          = aqi_q;
  assign category_level_o     = cat_q;
  assign dominant_pollutant_o = dom_q;

endmodule

/* rtl/air_quality_index_calc.sv */
// Air quality index from PM2.5 and PM10 readings: top level, control and register port.
// Depends on aqic_pkg, aqic_lane and aqic_merge.
//
// Takes one PM2.5/PM10 reading pair per beat and returns the overall index (0..500),
// its six-level category and the dominant pollutant. A new beat can be accepted every
// cycle unless an output stall has backed up to the first stage; each reading passes 12
// pipeline stages (segment search, interpolation multiply, nine divider stages of one
// quotient bit each for the rounded interpolation, and the merge/output register). Each
// stage holds independently, so stalls only push back as far as the first empty stage.
// Breakpoint tables (US EPA or QCVN) are selected through the standard_select register
// at address 0; change it only while no beats are in flight.
module air_quality_index_calc
  import aqic_pkg::*;
#(
  parameter int BREAKPOINT_COUNT = BREAKPOINT_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CONC_W-1:0]  pm25_tenths_i,
  input  logic [CONC_W-1:0]  pm10_tenths_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [INDEX_W-1:0] aqi_value_o,
  output logic [CAT_W-1:0]   category_level_o,
  output logic               dominant_pollutant_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  standard_e             std_q;
  logic                  cfg_wr;
  logic [PIPE_DEPTH-1:0] valid_q, valid_d, en;
  logic [INDEX_W-1:0]    pm25_index, pm10_index;

  // Register port: no wait states, writes land in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_STANDARD);
  assign prdata = (paddr[PADDR_W-1:2] == REG_STANDARD) ? PDATA_W'(std_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      std_q <= STD_EPA;
    end else if (cfg_wr) begin
      std_q <= standard_e'(pwdata[0]);
    end
  end

  // Stage enables: a stage loads when empty or when its beat moves on
  always_comb begin
    en[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || out_ready_i;
    for (int s = PIPE_DEPTH - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  // Advance valid bits alongside the payload
  assign valid_d = (en & {valid_q[PIPE_DEPTH-2:0], in_valid_i}) | (~en & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[PIPE_DEPTH-1];

  aqic_lane #(
    .BREAKPOINT_COUNT (BREAKPOINT_COUNT),
    .POLLUTANT        (POLL_PM25)
  ) u_lane_pm25 (
    .clk_i       (clk_i),
    .en_i        (en[PIPE_DEPTH-2:0]),
    .conc_i      (pm25_tenths_i),
    .standard_i  (std_q),
    .sub_index_o (pm25_index)
  );

  aqic_lane #(
    .BREAKPOINT_COUNT (BREAKPOINT_COUNT),
    .POLLUTANT        (POLL_PM10)
  ) u_lane_pm10 (
    .clk_i       (clk_i),
    .en_i        (en[PIPE_DEPTH-2:0]),
    .conc_i      (pm10_tenths_i),
    .standard_i  (std_q),
    .sub_index_o (pm10_index)
  );

  aqic_merge u_merge (
    .clk_i                (clk_i),
    .en_i                 (en[PIPE_DEPTH-1]),
    .pm25_index_i         (pm25_index),
    .pm10_index_i         (pm10_index),
    .aqi_value_o          (aqi_value_o),
    .category_level_o     (category_level_o),
    .dominant_pollutant_o (dominant_pollutant_o)
  );

  // A held beat never vanishes from its stage
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(valid_q & ~en) & ~valid_q) == '0))
    else $error("pipeline beat lost while held");

  // Input backpressure only when every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

  a_aqi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (aqi_value_o <= INDEX_MAX))
    else $error("index above 500");

  a_category: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (category_level_o == category_of(aqi_value_o)))
    else $error("category does not match index");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (std_q == standard_e'($past(pwdata[0]))))
    else $error("standard_select write not taken");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for air_quality_index_calc: directed table, then random readings.
// Depends on aqic_pkg and the RTL of the block; computes expected index results on its own.
module tb_top;
  import aqic_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 175;
  localparam int DRAIN_WAIT  = PIPE_DEPTH + 4;
  localparam int SEGMENTS    = 6;

  localparam logic [PADDR_W-1:0] ADDR_STANDARD = {REG_STANDARD, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  // Breakpoint tables in tenths of ug/m3 and the matching index breakpoints
  typedef logic [CONC_W-1:0] bp_list_t [SEGMENTS+1];
  localparam bp_list_t US_PM25  = '{0, 120, 354, 554, 1504, 2504, 5004};
  localparam bp_list_t US_PM10  = '{0, 540, 1540, 2540, 3540, 4240, 6040};
  localparam bp_list_t VN_PM25  = '{0, 250, 500, 800, 1500, 3500, 5000};
  localparam bp_list_t VN_PM10  = '{0, 500, 1500, 2500, 3500, 4200, 6000};
  localparam int unsigned AQI_STEPS [SEGMENTS+1] = '{0, 50, 100, 150, 200, 300, 500};

  typedef struct packed {
    logic [INDEX_W-1:0] aqi;
    category_e          cat;
    pollutant_e         dom;
  } aqi_result_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [PADDR_W-1:0] addr;
    logic [31:0]        data;
    logic [CONC_W-1:0]  pm25;
    logic [CONC_W-1:0]  pm10;
    logic               typed;
    aqi_result_t        res;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CONC_W-1:0]  pm25_tenths_i;
  logic [CONC_W-1:0]  pm10_tenths_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [INDEX_W-1:0] aqi_value_o;
  logic [CAT_W-1:0]   category_level_o;
  logic               dominant_pollutant_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  standard_e   std_sel;
  aqi_result_t aqi_expected_q [$];
  logic        fixed_valid;
  aqi_result_t fixed_result;
  logic        src_idle_en;
  logic        sink_idle_en;
  int unsigned sink_gap;
  int unsigned mismatch_count;
  int unsigned beats_checked;
  int unsigned cycle_count;

  air_quality_index_calc u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .pm25_tenths_i       (pm25_tenths_i),
    .pm10_tenths_i       (pm10_tenths_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .aqi_value_o         (aqi_value_o),
    .category_level_o    (category_level_o),
    .dominant_pollutant_o(dominant_pollutant_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Directed stimulus; rows with typed set carry a result read straight off the tables
  stim_row_t directed_rows [] = '{
    '{ROW_BEAT,  3'd0, 32'd0, 16'd0,     16'd0,     1'b1, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'hFFFF,  16'hFFFF,  1'b1, '{9'd500, CAT_HAZARDOUS,      POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd120,   16'd0,     1'b1, '{9'd50,  CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd0,     16'd540,   1'b1, '{9'd50,  CAT_GOOD,           POLL_PM10}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd5004,  16'd0,     1'b1, '{9'd500, CAT_HAZARDOUS,      POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd0,     16'd6040,  1'b1, '{9'd500, CAT_HAZARDOUS,      POLL_PM10}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd354,   16'd1540,  1'b1, '{9'd100, CAT_MODERATE,       POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd2504,  16'd4240,  1'b1, '{9'd300, CAT_VERY_UNHEALTHY, POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd5003,  16'd0,     1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd1,     16'd1,     1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd555,   16'd0,     1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'h8000,  16'h0001,  1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'h00FF,  16'hFF00,  1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd61,    16'd2000,  1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    // upper bits of the write are dropped, so this selects QCVN
    '{ROW_WRITE, ADDR_STANDARD, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, '{9'd0, CAT_GOOD, POLL_PM25}},
    // a write past the only register must leave the selection alone
    '{ROW_WRITE, ADDR_UNMAPPED, 32'h0000_0000, 16'd0, 16'd0, 1'b0, '{9'd0, CAT_GOOD, POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd250,   16'd0,     1'b1, '{9'd50,  CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd0,     16'd6000,  1'b1, '{9'd500, CAT_HAZARDOUS,      POLL_PM10}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'hFFFF,  16'd0,     1'b1, '{9'd500, CAT_HAZARDOUS,      POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd1500,  16'd3500,  1'b1, '{9'd200, CAT_UNHEALTHY,      POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd5000,  16'd5999,  1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd125,   16'd7,     1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}},
    // even data clears the selection back to US EPA
    '{ROW_WRITE, ADDR_STANDARD, 32'hFFFF_FFFE, 16'd0, 16'd0, 1'b0, '{9'd0, CAT_GOOD, POLL_PM25}},
    '{ROW_BEAT,  3'd0, 32'd0, 16'd1000,  16'd3000,  1'b0, '{9'd0,   CAT_GOOD,           POLL_PM25}}
  };

  function automatic bp_list_t bp_list_of(pollutant_e poll, standard_e sel);
    bp_list_t bp;
    case ({poll, sel})
      {POLL_PM25, STD_EPA}:  bp = US_PM25;
      {POLL_PM25, STD_QCVN}: bp = VN_PM25;
      {POLL_PM10, STD_EPA}:  bp = US_PM10;
      default:               bp = VN_PM10;
    endcase
    return bp;
  endfunction

  // Piecewise linear sub-index, quotient rounded half up
  function automatic int unsigned sub_index_of(logic [CONC_W-1:0] c, pollutant_e poll,
                                               standard_e sel);
    bp_list_t        bp;
    longint unsigned num;
    longint unsigned span;
    bp = bp_list_of(poll, sel);
    if (c == 0) return 0;
    if (c >= bp[SEGMENTS]) return 500;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (c >= bp[i] && c <= bp[i+1]) begin
        span = bp[i+1] - bp[i];
        num  = longint'(AQI_STEPS[i+1] - AQI_STEPS[i]) * longint'(c - bp[i]);
        return AQI_STEPS[i] + int'((2 * num + span) / (2 * span));
      end
    end
    return 0;
  endfunction

  function automatic aqi_result_t aqi_of(logic [CONC_W-1:0] pm25, logic [CONC_W-1:0] pm10,
                                         standard_e sel);
    aqi_result_t r;
    int unsigned a25;
    int unsigned a10;
    int unsigned top;
    a25 = sub_index_of(pm25, POLL_PM25, sel);
    a10 = sub_index_of(pm10, POLL_PM10, sel);
    if (a25 >= a10) begin
      top   = a25;
      r.dom = POLL_PM25;
    end else begin
      top   = a10;
      r.dom = POLL_PM10;
    end
    r.aqi = top[INDEX_W-1:0];
    if (top <= 50)       r.cat = CAT_GOOD;
    else if (top <= 100) r.cat = CAT_MODERATE;
    else if (top <= 150) r.cat = CAT_SENSITIVE;
    else if (top <= 200) r.cat = CAT_UNHEALTHY;
    else if (top <= 300) r.cat = CAT_VERY_UNHEALTHY;
    else                 r.cat = CAT_HAZARDOUS;
    return r;
  endfunction

  // Random concentration: zeros, full range, in-table, near breakpoints, saturation
  function automatic logic [CONC_W-1:0] random_conc(pollutant_e poll, standard_e sel);
    bp_list_t bp;
    bp = bp_list_of(poll, sel);
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return CONC_W'($urandom_range(0, 65535));
      7, 8:    return CONC_W'(bp[$urandom_range(1, SEGMENTS)] + $urandom_range(0, 4) - 2);
      9:       return CONC_W'($urandom_range(60000, 65535));
      default: return CONC_W'($urandom_range(1, bp[SEGMENTS] + 50));
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", beats_checked, what, got, want);
    mismatch_count++;
  endtask

  // Let the last accepted beat be recorded, hold until every expected result has come,
  // then let the pipeline settle
  task automatic wait_drained();
    @(posedge clk_i);
    while (aqi_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_STANDARD) std_sel = standard_e'(data[0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check_standard();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_STANDARD;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== PDATA_W'(std_sel)) report_mismatch("standard_select readback", prdata, std_sel);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one reading pair, with an occasional idle burst ahead of it
  task automatic send_reading(logic [CONC_W-1:0] pm25, logic [CONC_W-1:0] pm10,
                              logic typed, aqi_result_t res);
    if (src_idle_en && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pm25_tenths_i <= pm25;
    pm10_tenths_i <= pm10;
    fixed_valid   <= typed;
    fixed_result  <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Record the expected result of every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (fixed_valid) aqi_expected_q.push_back(fixed_result);
      else aqi_expected_q.push_back(aqi_of(pm25_tenths_i, pm10_tenths_i, std_sel));
    end
  end

  // Drive output backpressure in bursts and check each result beat
  always @(posedge clk_i) begin
    aqi_result_t want;
    if (sink_gap > 0) begin
      sink_gap    <= sink_gap - 1;
      out_ready_i <= 1'b0;
    end else if (sink_idle_en && $urandom_range(5) == 0) begin
      sink_gap    <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (aqi_expected_q.size() == 0) begin
        report_mismatch("unexpected result, aqi_value", aqi_value_o, 0);
      end else begin
        want = aqi_expected_q.pop_front();
        if (aqi_value_o !== want.aqi) report_mismatch("aqi_value", aqi_value_o, want.aqi);
        if (category_level_o !== want.cat)
          report_mismatch("category_level", category_level_o, want.cat);
        if (dominant_pollutant_o !== want.dom)
          report_mismatch("dominant_pollutant", dominant_pollutant_o, want.dom);
      end
      beats_checked++;
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] wdata;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    pm25_tenths_i  = '0;
    pm10_tenths_i  = '0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fixed_valid    = 1'b0;
    fixed_result   = '0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    sink_gap       = 0;
    std_sel        = STD_EPA;
    mismatch_count = 0;
    beats_checked  = 0;
    cycle_count    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check_standard();

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        in_valid_i <= 1'b0;
        wait_drained();
        apb_write(directed_rows[i].addr, directed_rows[i].data);
        apb_check_standard();
      end else begin
        send_reading(directed_rows[i].pm25, directed_rows[i].pm10,
                     directed_rows[i].typed, directed_rows[i].res);
      end
    end

    // Random phases alternating the standard; the last one runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      wdata    = $urandom;
      wdata[0] = ph[0];
      apb_write(ADDR_STANDARD, wdata);
      apb_check_standard();
      src_idle_en  <= (ph != PHASES - 1);
      sink_idle_en <= (ph != PHASES - 1);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_reading(random_conc(POLL_PM25, std_sel), random_conc(POLL_PM10, std_sel),
                     1'b0, '0);
      end
    end

    // Drain and report
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (PIPE_DEPTH) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/aqic_pkg.sv
rtl/aqic_div.sv
rtl/aqic_lane.sv
rtl/aqic_merge.sv
rtl/air_quality_index_calc.sv
tb/tb_top.sv
